@@ rtl/ghrp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ghrp_pkg: shared types and constants for the gizmo handle ray picker
// Holds distance type, sideband bundle, register indexes and pick codes.
// ----------------------------------------------------------------------------
package ghrp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int REG_W         = 24;
	localparam int IDX_W         = 8;
	// bound minus origin never exceeds 34 bits of magnitude
	localparam int DIFF_W        = 35;
	localparam int DIV_STEPS     = 31;
	// prep register, one register per quotient bit, saturation register
	localparam int DIV_LAT       = DIV_STEPS + 2;

	localparam logic [IDX_W-1:0] REG_AXIS_LENGTH = 8'd0;
	localparam logic [IDX_W-1:0] REG_HALF_SIZE   = 8'd1;

	localparam logic [1:0] PICK_NONE = 2'd0;
	localparam logic [1:0] PICK_X    = 2'd1;
	localparam logic [1:0] PICK_Y    = 2'd2;
	localparam logic [1:0] PICK_Z    = 2'd3;

	localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

	typedef logic signed [31:0] dist_t;

	// per axis: direction is zero, origin inside off-axis slab, inside on-axis slab
	typedef struct packed {
		logic [2:0] dz;
		logic [2:0] in_off;
		logic [2:0] in_on;
	} side_t;

endpackage
`default_nettype wire

@@ rtl/ghrp_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ghrp_div: pipelined saturating fixed point divider
// Computes (num << FRAC_BITS) / den truncated toward zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
module ghrp_div #(
	parameter int FRAC_BITS = ghrp_pkg::FRAC_BITS_DEF
) (
	input  wire                                     clk,
	input  wire                                     en,
	input  wire logic signed [ghrp_pkg::DIFF_W-1:0] num,
	input  wire logic signed [31:0]                 den,
	output ghrp_pkg::dist_t                         quo
);
	import ghrp_pkg::*;

	localparam int NW   = DIFF_W + FRAC_BITS;
	localparam int HI_W = NW - DIV_STEPS;

	logic [DIFF_W-1:0] nmag;
	logic [NW-1:0]     nfull;
	logic [31:0]       dmag;
	logic [HI_W-1:0]   nhi;

	logic [31:0] rem_s [DIV_STEPS+1];
	logic [30:0] low_s [DIV_STEPS+1];
	logic [30:0] q_s   [DIV_STEPS+1];
	logic [31:0] dm_s  [DIV_STEPS+1];
	logic        neg_s [DIV_STEPS+1];
	logic        ovf_s [DIV_STEPS+1];
	dist_t       quo_q;

	always_comb begin
		nmag  = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
		nfull = {nmag, {FRAC_BITS{1'b0}}};
		dmag  = den[31] ? 32'(-den) : 32'(den);
		nhi   = nfull[NW-1:DIV_STEPS];
	end

	// prep: magnitudes, sign and overflow check
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 32'(nhi);
			low_s[0] <= nfull[30:0];
			q_s[0]   <= '0;
			dm_s[0]  <= dmag;
			neg_s[0] <= num[DIFF_W-1] ^ den[31];
			ovf_s[0] <= 33'(nhi) >= {1'b0, dmag};
		end
	end

	// one restoring step per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [32:0] rem2;
		logic [32:0] sub;
		logic        ge;
		always_comb begin
			rem2 = {rem_s[j], low_s[j][30]};
			sub  = rem2 - {1'b0, dm_s[j]};
			ge   = rem2 >= {1'b0, dm_s[j]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? sub[31:0] : rem2[31:0];
				low_s[j+1] <= {low_s[j][29:0], 1'b0};
				q_s[j+1]   <= {q_s[j][29:0], ge};
				dm_s[j+1]  <= dm_s[j];
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	// apply sign and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[DIV_STEPS]) begin
				quo_q <= neg_s[DIV_STEPS] ? T_MIN : T_MAX;
			end else begin
				quo_q <= neg_s[DIV_STEPS] ? -$signed({1'b0, q_s[DIV_STEPS]})
				                          : $signed({1'b0, q_s[DIV_STEPS]});
			end
		end
	end

	assign quo = quo_q;

endmodule
`default_nettype wire

@@ rtl/ghrp_select.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ghrp_select: slab interval per handle box and nearest-hit selection
// Three register stages; the last one is the output register.
// ----------------------------------------------------------------------------
module ghrp_select (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    in_vld,
	input  ghrp_pkg::side_t        side,
	input  ghrp_pkg::dist_t        t [3][4],
	output logic                   out_vld,
	output logic [1:0]             pick
);
	import ghrp_pkg::*;

	dist_t lo_s1 [3][3];
	dist_t hi_s1 [3][3];
	side_t side_s1;
	logic  vld_s1;

	dist_t ent_s2 [3];
	logic  hit_s2 [3];
	logic  vld_s2;

	logic       vld_q;
	logic [1:0] pick_q;

	dist_t lo_c [3][3];
	dist_t hi_c [3][3];
	dist_t ent_c [3];
	logic  hit_c [3];
	logic [1:0] pick_c;

	// order both slab distances of each box axis
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int i = 0; i < 3; i++) begin
				dist_t ta;
				dist_t tb;
				ta = (i == a) ? t[i][2] : t[i][0];
				tb = (i == a) ? t[i][3] : t[i][1];
				lo_c[a][i] = (ta > tb) ? tb : ta;
				hi_c[a][i] = (ta > tb) ? ta : tb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_q  <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= lo_c;
			hi_s1   <= hi_c;
			side_s1 <= side;
		end
	end

	// narrow the interval; a parallel axis only checks the origin
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dist_t en_t;
			dist_t ex_t;
			logic  ok;
			en_t = '0;
			ex_t = T_MAX;
			ok   = 1'b1;
			for (int i = 0; i < 3; i++) begin
				if (side_s1.dz[i]) begin
					ok = ok & ((i == a) ? side_s1.in_on[i] : side_s1.in_off[i]);
				end else begin
					if (lo_s1[a][i] > en_t) en_t = lo_s1[a][i];
					if (hi_s1[a][i] < ex_t) ex_t = hi_s1[a][i];
				end
			end
			ent_c[a] = en_t;
			hit_c[a] = ok && (en_t <= ex_t);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s2 <= ent_c;
			hit_s2 <= hit_c;
		end
	end

	// strictly nearer wins, so ties stay with the lower axis
	always_comb begin
		dist_t best;
		best   = '0;
		pick_c = PICK_NONE;
		if (hit_s2[0]) begin
			pick_c = PICK_X;
			best   = ent_s2[0];
		end
		if (hit_s2[1] && (pick_c == PICK_NONE || ent_s2[1] < best)) begin
			pick_c = PICK_Y;
			best   = ent_s2[1];
		end
		if (hit_s2[2] && (pick_c == PICK_NONE || ent_s2[2] < best)) begin
			pick_c = PICK_Z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pick_q <= pick_c;
		end
	end

	assign out_vld = vld_q;
	assign pick    = pick_q;

endmodule
`default_nettype wire

@@ rtl/gizmo_handle_ray_pick_top.sv @@
`default_nettype none
// Pipeline: 38 register stages between the accepting edge and result valid:
//   2 input stages, 33-stage divider, 3 interval and selection stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: clears all valid bits and loads axis_length and handle_half_size defaults.
// ----------------------------------------------------------------------------
// gizmo_handle_ray_pick_top: ray pick against three scale gizmo handle boxes
// Slab test per box with twelve pipelined dividers, then nearest hit select.
// ----------------------------------------------------------------------------
module gizmo_handle_ray_pick_top #(
	parameter int FRAC_BITS = ghrp_pkg::FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire logic [ghrp_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [ghrp_pkg::REG_W-1:0]      cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire logic signed [31:0]              ray_origin_x,
	input  wire logic signed [31:0]              ray_origin_y,
	input  wire logic signed [31:0]              ray_origin_z,
	input  wire logic signed [31:0]              ray_direction_x,
	input  wire logic signed [31:0]              ray_direction_y,
	input  wire logic signed [31:0]              ray_direction_z,
	input  wire logic signed [31:0]              gizmo_center_x,
	input  wire logic signed [31:0]              gizmo_center_y,
	input  wire logic signed [31:0]              gizmo_center_z,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [1:0]                           picked_axis
);
	import ghrp_pkg::*;

	// register defaults: 1.5 and 0.12, saturated to the register width
	localparam longint REG_MAX = (64'd1 << REG_W) - 1;
	localparam longint LEN_RAW = (64'd3 << FRAC_BITS) / 2;
	localparam longint HALF_RAW = (64'd12 << FRAC_BITS) / 100;
	localparam logic [REG_W-1:0] LEN_RST = REG_W'((LEN_RAW > REG_MAX) ? REG_MAX : LEN_RAW);
	localparam logic [REG_W-1:0] HALF_RST = REG_W'((HALF_RAW > REG_MAX) ? REG_MAX : HALF_RAW);

	logic [REG_W-1:0] axis_len_q;
	logic [REG_W-1:0] half_q;

	logic en;
	logic sel_vld;

	logic signed [31:0] o_s1 [3];
	logic signed [31:0] d_s1 [3];
	logic signed [31:0] c_s1 [3];
	logic               vld_s1;

	logic signed [DIFF_W-1:0] diff_s2 [3][4];
	logic signed [31:0]       d_s2 [3];
	side_t                    side_s2;
	logic                     vld_s2;

	logic signed [DIFF_W-1:0] diff_c [3][4];
	side_t                    side_c;

	side_t side_dl [DIV_LAT];
	logic  vld_dl  [DIV_LAT];
	dist_t t_div   [3][4];

	// advance everything unless a finished result is still waiting
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_len_q <= LEN_RST;
			half_q     <= HALF_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_AXIS_LENGTH) axis_len_q <= cfg_data;
			if (cfg_index == REG_HALF_SIZE)   half_q     <= cfg_data;
		end
	end

	// stage 1: capture the item
	always_ff @(posedge clk) begin
		if (en) begin
			o_s1 <= '{ray_origin_x, ray_origin_y, ray_origin_z};
			d_s1 <= '{ray_direction_x, ray_direction_y, ray_direction_z};
			c_s1 <= '{gizmo_center_x, gizmo_center_y, gizmo_center_z};
		end
	end

	// stage 2: box bounds minus origin; columns are off-axis lo/hi, on-axis lo/hi
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [DIFF_W-1:0] rel;
			logic signed [DIFF_W-1:0] hs;
			logic signed [DIFF_W-1:0] ln;
			rel = DIFF_W'(c_s1[i]) - DIFF_W'(o_s1[i]);
			hs  = $signed({{(DIFF_W-REG_W){1'b0}}, half_q});
			ln  = $signed({{(DIFF_W-REG_W){1'b0}}, axis_len_q});
			diff_c[i][0] = rel - hs;
			diff_c[i][1] = rel + hs;
			diff_c[i][2] = rel + ln - hs;
			diff_c[i][3] = rel + ln + hs;
			side_c.dz[i]     = (d_s1[i] == '0);
			side_c.in_off[i] = (diff_c[i][0] <= 0) && (diff_c[i][1] >= 0);
			side_c.in_on[i]  = (diff_c[i][2] <= 0) && (diff_c[i][3] >= 0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2 <= diff_c;
			d_s2    <= d_s1;
			side_s2 <= side_c;
		end
	end

	// twelve slab distances
	for (genvar i = 0; i < 3; i++) begin : g_axis
		for (genvar j = 0; j < 4; j++) begin : g_bound
			ghrp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
				.clk (clk),
				.en  (en),
				.num (diff_s2[i][j]),
				.den (d_s2[i]),
				.quo (t_div[i][j])
			);
		end
	end

	// carry flags alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			side_dl[0] <= side_s2;
			for (int k = 1; k < DIV_LAT; k++) side_dl[k] <= side_dl[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) vld_dl[k] <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_dl[0] <= vld_s2;
			for (int k = 1; k < DIV_LAT; k++) vld_dl[k] <= vld_dl[k-1];
		end
	end

	ghrp_select u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_dl[DIV_LAT-1]),
		.side    (side_dl[DIV_LAT-1]),
		.t       (t_div),
		.out_vld (sel_vld),
		.pick    (picked_axis)
	);

	assign out_valid = sel_vld;

`ifndef SYNTH
	// hold the valid chain while stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s1) && $stable(vld_s2) && $stable(vld_dl[DIV_LAT-1])))
		else $error("pipeline valid moved during stall");

	// an accepted item enters stage 1
	a_accept_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted item lost at entry");

	// advance items from stage 2 into the divider
	a_tail_move: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s2) |=> vld_dl[0])
		else $error("item lost entering divider");
`endif

endmodule
`default_nettype wire

@@ test/gizmo_handle_ray_pick_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gizmo_handle_ray_pick_top_tb: self-checking bench for the handle ray picker
// Streams rays at the block under random bursts and output stalls, predicts
// the nearest hit handle per item with a 64-bit slab test and checks each pick.
// ----------------------------------------------------------------------------
module gizmo_handle_ray_pick_top_tb;
	import ghrp_pkg::*;

	localparam int PIPE_DEPTH = 38;

	// one ray query as driven onto the ports
	typedef struct {
		logic signed [31:0] org [3];
		logic signed [31:0] dir [3];
		logic signed [31:0] ctr [3];
	} ray_item_t;

	// expected picks in order, plus the register copy they depend on
	class pick_scoreboard;
		logic [1:0] picks_q [$];
		logic [REG_W-1:0] arm_len;
		logic [REG_W-1:0] half_edge;
		int mismatches;

		function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
			if (idx == REG_AXIS_LENGTH)
				arm_len = val;
			else if (idx == REG_HALF_SIZE)
				half_edge = val;
		endfunction

		function longint clamp_t(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		// slab test of one box; returns 1 on hit and the clamped entry distance
		function bit slab_hit(ray_item_t r, int arm, output longint t_in);
			longint lo, hi, o, d, t1, t2, tmp, t_enter, t_exit, c;
			t_enter = 0;
			t_exit = 64'sd2147483647;
			t_in = 0;
			for (int i = 0; i < 3; i++) begin
				c = longint'(r.ctr[i]) + ((i == arm) ? longint'(arm_len) : 0);
				lo = c - longint'(half_edge);
				hi = c + longint'(half_edge);
				o = r.org[i];
				d = r.dir[i];
				if (d == 0) begin
					if (o < lo || o > hi)
						return 0;
				end else begin
					t1 = clamp_t(((lo - o) * 65536) / d);
					t2 = clamp_t(((hi - o) * 65536) / d);
					if (t1 > t2) begin
						tmp = t1;
						t1 = t2;
						t2 = tmp;
					end
					if (t1 > t_enter) t_enter = t1;
					if (t2 < t_exit) t_exit = t2;
					if (t_enter > t_exit)
						return 0;
				end
			end
			t_in = t_enter;
			return 1;
		endfunction

		function void note_ray(ray_item_t r);
			bit found;
			longint best, t;
			logic [1:0] pick;
			found = 0;
			best = 0;
			pick = PICK_NONE;
			for (int a = 0; a < 3; a++)
				if (slab_hit(r, a, t) && (!found || t < best)) begin
					found = 1;
					best = t;
					pick = (a == 0) ? PICK_X : (a == 1) ? PICK_Y : PICK_Z;
				end
			picks_q.push_back(pick);
		endfunction

		function void check_pick(logic [1:0] got);
			logic [1:0] want;
			if (picks_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pick %0d with nothing pending", got);
				return;
			end
			want = picks_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("picked_axis mismatch: expected %0d, actual %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] ray_origin_x = 0, ray_origin_y = 0, ray_origin_z = 0;
	logic signed [31:0] ray_direction_x = 0, ray_direction_y = 0, ray_direction_z = 0;
	logic signed [31:0] gizmo_center_x = 0, gizmo_center_y = 0, gizmo_center_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] picked_axis;

	pick_scoreboard sb;
	bit stall_on = 1;

	gizmo_handle_ray_pick_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
		.ray_origin_z(ray_origin_z),
		.ray_direction_x(ray_direction_x), .ray_direction_y(ray_direction_y),
		.ray_direction_z(ray_direction_z),
		.gizmo_center_x(gizmo_center_x), .gizmo_center_y(gizmo_center_y),
		.gizmo_center_z(gizmo_center_z),
		.out_valid(out_valid), .out_ready(out_ready), .picked_axis(picked_axis)
	);

	always #5 clk = ~clk;

	// receiver: stall in runs that alternate between dense and sparse phases
	int stall_phase = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_pick(picked_axis);
		stall_phase <= stall_phase + 1;
		if (!stall_on)
			out_ready <= 1;
		else if (stall_phase[8:6] == 3'd0)
			out_ready <= 1;
		else if (stall_phase[8:6] == 3'd5)
			out_ready <= ($urandom_range(0, 7) == 0);
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	// one write, then cfg_we is dropped and the task idles so back to back writes never collide
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// drive one item and hold it until accepted; valid stays high between items of a burst
	task automatic send_ray(ray_item_t r, bit last_in_burst);
		in_valid <= 1;
		ray_origin_x <= r.org[0];
		ray_origin_y <= r.org[1];
		ray_origin_z <= r.org[2];
		ray_direction_x <= r.dir[0];
		ray_direction_y <= r.dir[1];
		ray_direction_z <= r.dir[2];
		gizmo_center_x <= r.ctr[0];
		gizmo_center_y <= r.ctr[1];
		gizmo_center_z <= r.ctr[2];
		do @(posedge clk); while (!in_ready);
		sb.note_ray(r);
		if (last_in_burst)
			in_valid <= 0;
	endtask

	// wait for every pick, then let the pipe drain before touching registers
	task automatic drain();
		while (sb.picks_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 0;
			default: return $urandom;
		endcase
	endfunction

	// aimed ray: start near the gizmo, point at one handle or the gizmo center with small jitter
	function automatic ray_item_t aimed_ray();
		ray_item_t r;
		int tgt;
		tgt = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			r.ctr[i] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			r.org[i] = r.ctr[i] + $signed($urandom_range(0, 32'h000A_0000))
				- 32'sh0005_0000;
		end
		for (int i = 0; i < 3; i++) begin
			logic signed [31:0] aim;
			aim = r.ctr[i] + ((i == tgt) ? $signed({8'd0, sb.arm_len}) : 0)
				+ $signed($urandom_range(0, 32'h4000)) - 32'sh2000;
			r.dir[i] = (aim - r.org[i]) >>> $urandom_range(0, 4);
			if ($urandom_range(0, 9) == 0)
				r.dir[i] = 0;
		end
		return r;
	endfunction

	function automatic ray_item_t noise_ray();
		ray_item_t r;
		for (int i = 0; i < 3; i++) begin
			r.org[i] = rand_word();
			r.dir[i] = rand_word();
			r.ctr[i] = rand_word();
		end
		return r;
	endfunction

	// drop valid only where a gap follows, so bursts can run back to back
	task automatic random_phase(int count);
		int left, burst;
		bit gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			if (burst > left)
				burst = left;
			gap = ($urandom_range(0, 2) != 0) || (burst == left);
			for (int k = 0; k < burst; k++)
				send_ray(($urandom_range(0, 4) == 0) ? noise_ray() : aimed_ray(),
					gap && (k == burst - 1));
			left -= burst;
			if (gap)
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	initial begin
		ray_item_t r;
		arst_n <= 1'b0;
		sb = new();
		sb.arm_len = 24'd98304;
		sb.half_edge = 24'd7864;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: default registers
		for (int i = 0; i < 3; i++) begin
			r.ctr[i] = 0;
			r.org[i] = 0;
			r.dir[i] = 0;
		end
		// each axis hit head-on
		for (int a = 0; a < 3; a++) begin
			r.org = '{-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000};
			r.dir = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};
			r.dir[a] = 32'sh0002_8000;
			send_ray(r, 0);
		end
		// parallel along Y and Z through the X handle, just outside its edge and on it
		r.org = '{32'sh0001_8000, 0, 0};
		r.dir = '{32'sh0001_0000, 0, 0};
		send_ray(r, 0);
		r.org = '{-32'sh0001_0000, 32'sd7865, 0};
		send_ray(r, 0);
		r.org = '{-32'sh0001_0000, 32'sd7864, 0};
		send_ray(r, 0);
		// origin inside a box: entry clamps at zero
		r.org = '{32'sh0001_8000, 0, 0};
		r.dir = '{-32'sd1, 32'sd1, 32'sd1};
		send_ray(r, 0);
		// diagonal from the far corner between the X and Y handles, missing both
		r.org = '{32'sh0001_8000, 32'sh0001_8000, 0};
		r.dir = '{-32'sh0001_0000, 32'sh0001_0000, 0};
		send_ray(r, 0);
		// saturating quotients: tiny directions, huge coordinates
		r.org = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
		r.dir = '{32'sd1, -32'sd1, 32'sh7FFF_FFFF};
		r.ctr = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
		send_ray(r, 0);
		r.dir = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		send_ray(r, 0);
		r.org = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		r.dir = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		r.ctr = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		send_ray(r, 0);
		for (int k = 0; k < 8; k++)
			send_ray(noise_ray(), k == 7);
		drain();

		// directed with extreme registers: zero-size boxes at the gizmo center
		write_reg(REG_AXIS_LENGTH, 24'd0);
		write_reg(REG_HALF_SIZE, 24'd0);
		r.org = '{-32'sh0001_0000, 0, 0};
		r.dir = '{32'sh0001_0000, 0, 0};
		r.ctr = '{0, 0, 0};
		send_ray(r, 1);
		drain();
		write_reg(REG_HALF_SIZE, 24'hFFFFFF);
		drain();

		// random phases over several register settings
		write_reg(REG_AXIS_LENGTH, 24'hFFFFFF);
		write_reg(REG_HALF_SIZE, 24'hFFFFFF);
		random_phase(100);
		drain();
		write_reg(REG_AXIS_LENGTH, 24'd98304);
		write_reg(REG_HALF_SIZE, 24'd7864);
		random_phase(400);
		drain();
		write_reg(REG_AXIS_LENGTH, 24'($urandom_range(0, 32'h0003_0000)));
		write_reg(REG_HALF_SIZE, 24'($urandom_range(0, 32'h0000_8000)));
		stall_on = 0;
		random_phase(150);
		stall_on = 1;
		drain();
		write_reg(REG_AXIS_LENGTH, 24'd0);
		write_reg(REG_HALF_SIZE, 24'($urandom_range(1, 32'h0001_0000)));
		random_phase(280);

		drain();
		if (sb.mismatches == 0 && sb.picks_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ gizmo_handle_ray_pick_top.f @@
rtl/ghrp_pkg.sv
rtl/ghrp_div.sv
rtl/ghrp_select.sv
rtl/gizmo_handle_ray_pick_top.sv
test/gizmo_handle_ray_pick_top_tb.sv
